// ===== hw/rtl/oaids_pkg.sv =====
// ----------------------------------------------------------------------------
// oaids_pkg: shared definitions for the ordered array list core
// Holds the operation and status codes, the sequencer states, the result
// record handed from the sequencer to the output stage, and default sizes.
// ----------------------------------------------------------------------------
package oaids_pkg;

    localparam int DEPTH_DEF = 64;   // default number of list entries
    localparam int VAL_W     = 32;   // width of one entry
    localparam int POS_W     = 7;    // width of positions and counts on the ports
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SCAN,
        S_FETCH,
        S_RESP
    } state_t;

    // One finished result, as it leaves the sequencer.
    typedef struct packed {
        logic [POS_W-1:0]        count;
        logic signed [VAL_W-1:0] rval;
        logic [POS_W-1:0]        fpos;
        status_t                 status;
    } res_t;

endpackage

// ===== hw/rtl/oaids_mem.sv =====
// ----------------------------------------------------------------------------
// oaids_mem: list storage
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module oaids_mem #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [oaids_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [oaids_pkg::VAL_W-1:0] rdata
);

    logic signed [oaids_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/oaids_seq.sv =====
// ----------------------------------------------------------------------------
// oaids_seq: operation sequencer
// Checks each request, then walks the storage one entry per cycle through a
// single read/write port pair to shift, scan or fetch, and stages the result.
// ----------------------------------------------------------------------------
module oaids_seq #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request
    input  logic                               req_valid,
    output logic                               req_ready,
    input  oaids_pkg::op_t                     req_op,
    input  logic signed [oaids_pkg::VAL_W-1:0] req_val,
    input  logic [oaids_pkg::POS_W-1:0]        req_pos,
    // result
    output logic                               res_valid,
    input  logic                               out_free,
    output oaids_pkg::res_t                    res,
    // storage
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_waddr,
    output logic signed [oaids_pkg::VAL_W-1:0] mem_wdata,
    output logic [AW-1:0]                      mem_raddr,
    input  logic signed [oaids_pkg::VAL_W-1:0] mem_rdata
);

    localparam int PW = oaids_pkg::POS_W;

    oaids_pkg::state_t                  state_reg, state_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [CW-1:0]                      rem_reg, rem_next;
    logic [AW-1:0]                      idx_reg, idx_next;
    logic                               pend_reg, pend_next;
    logic [AW-1:0]                      pend_addr_reg, pend_addr_next;
    logic signed [oaids_pkg::VAL_W-1:0] val_reg, val_next;
    logic [PW-1:0]                      pos_reg, pos_next;
    oaids_pkg::res_t                    res_reg, res_next;

    logic [PW-1:0] cnt_w;
    logic [PW-1:0] cnt_inc_w;
    logic [PW-1:0] cnt_dec_w;

    assign cnt_w     = PW'(cnt_reg);
    assign cnt_inc_w = cnt_w + PW'(1);
    assign cnt_dec_w = cnt_w - PW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oaids_pkg::S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        res_reg       <= res_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = idx_reg;

        case (state_reg)
            oaids_pkg::S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    val_next        = req_val;
                    pos_next        = req_pos;
                    res_next.status = oaids_pkg::ST_OK;
                    res_next.fpos   = '0;
                    res_next.rval   = '0;
                    res_next.count  = cnt_w;
                    case (req_op)
                        oaids_pkg::OP_INSERT: begin
                            if (req_pos == '0 || req_pos > cnt_inc_w) begin
                                res_next.status = oaids_pkg::ST_BADPOS;
                                state_next      = oaids_pkg::S_RESP;
                            end else if (cnt_reg == CW'(DEPTH)) begin
                                res_next.status = oaids_pkg::ST_FULL;
                                state_next      = oaids_pkg::S_RESP;
                            end else begin
                                rem_next   = CW'(cnt_inc_w - req_pos);
                                idx_next   = AW'(cnt_reg - CW'(1));
                                state_next = oaids_pkg::S_SHIFT_UP;
                            end
                        end
                        oaids_pkg::OP_DELETE: begin
                            if (req_pos == '0 || req_pos > cnt_w) begin
                                res_next.status = oaids_pkg::ST_BADPOS;
                                state_next      = oaids_pkg::S_RESP;
                            end else begin
                                rem_next   = CW'(cnt_w - req_pos);
                                idx_next   = AW'(req_pos);
                                state_next = oaids_pkg::S_SHIFT_DN;
                            end
                        end
                        oaids_pkg::OP_SEARCH: begin
                            rem_next   = cnt_reg;
                            idx_next   = '0;
                            state_next = oaids_pkg::S_SCAN;
                        end
                        default: begin
                            if (req_pos == '0 || req_pos > cnt_w) begin
                                res_next.status = oaids_pkg::ST_BADPOS;
                                state_next      = oaids_pkg::S_RESP;
                            end else begin
                                idx_next   = AW'(req_pos - PW'(1));
                                state_next = oaids_pkg::S_FETCH;
                            end
                        end
                    endcase
                end
            end

            // Walk from the top entry down, copying each entry one place up.
            oaids_pkg::S_SHIFT_UP: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg + AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (rem_reg != '0) begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg - AW'(1);
                    rem_next       = rem_reg - CW'(1);
                end else if (!pend_reg) begin
                    mem_we         = 1'b1;
                    mem_waddr      = AW'(pos_reg - PW'(1));
                    mem_wdata      = val_reg;
                    cnt_next       = cnt_reg + CW'(1);
                    res_next.count = cnt_inc_w;
                    state_next     = oaids_pkg::S_RESP;
                end
            end

            // Walk upward from the hole, copying each entry one place down.
            oaids_pkg::S_SHIFT_DN: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (rem_reg != '0) begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + AW'(1);
                    rem_next       = rem_reg - CW'(1);
                end else if (!pend_reg) begin
                    cnt_next       = cnt_reg - CW'(1);
                    res_next.count = cnt_dec_w;
                    state_next     = oaids_pkg::S_RESP;
                end
            end

            oaids_pkg::S_SCAN: begin
                if (pend_reg && mem_rdata == val_reg) begin
                    res_next.fpos = PW'(pend_addr_reg) + PW'(1);
                    state_next    = oaids_pkg::S_RESP;
                end else if (rem_reg != '0) begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + AW'(1);
                    rem_next       = rem_reg - CW'(1);
                end else if (!pend_reg) begin
                    res_next.status = oaids_pkg::ST_NOTFOUND;
                    state_next      = oaids_pkg::S_RESP;
                end
            end

            oaids_pkg::S_FETCH: begin
                if (pend_reg) begin
                    res_next.rval = mem_rdata;
                    state_next    = oaids_pkg::S_RESP;
                end else begin
                    pend_next = 1'b1;
                end
            end

            oaids_pkg::S_RESP: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = oaids_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = oaids_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // The count never goes beyond the storage size.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // Storage is only written while shifting.
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == oaids_pkg::S_SHIFT_UP ||
                    state_reg == oaids_pkg::S_SHIFT_DN))
        else $error("storage write outside a shift");

    // The count moves by exactly one, and only at the end of a shift.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cnt_reg) |->
            (($past(state_reg) == oaids_pkg::S_SHIFT_UP &&
              cnt_reg == CW'($past(cnt_reg) + CW'(1))) ||
             ($past(state_reg) == oaids_pkg::S_SHIFT_DN &&
              cnt_reg == CW'($past(cnt_reg) - CW'(1)))))
        else $error("entry count changed unexpectedly");

    // A result is presented only after the request side has closed.
    a_resp_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !req_ready && !mem_we)
        else $error("result staged while busy");

endmodule

// ===== hw/rtl/ordered_array_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search_core: positional array list of words
// Packed list of signed 32-bit entries with insert, delete, search and read
// at 1-based positions, behind a streaming request and result interface.
// ----------------------------------------------------------------------------
// The core keeps up to DEPTH signed 32-bit entries packed from position 1 and
// answers every request transaction with exactly one result transaction.
// Insert moves the entries from the given position up one place and delete
// moves those above it down, one entry per clock, through a storage with one
// write port, one read port and registered read data. A search reads entries
// from the bottom up, one per clock, and stops at the first match. A read
// fetches a single entry, and a request rejected for a bad position or a full
// list goes straight to the result. The worst case, a search of a full list
// with no match, is set by the one-entry-per-cycle walk over the storage port.
// The core takes one request transaction at a time; s_tready is low from
// acceptance until the result has been handed to the output register, and a
// result may wait there for m_tready while the next request is taken. The
// storage needs no clearing after reset, since only entries below the current
// count are ever read.
module ordered_array_insert_delete_search_core #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [8:2] found_position,
                                   // [40:9] read_value, [47:41] entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Request fields unpacked from the slave side.
    oaids_pkg::op_t                     req_op;
    logic signed [oaids_pkg::VAL_W-1:0] req_val;
    logic [oaids_pkg::POS_W-1:0]        req_pos;

    assign req_op  = oaids_pkg::op_t'(s_tuser);
    assign req_val = s_tdata[31:0];
    assign req_pos = s_tdata[38:32];

    // Storage connections.
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic signed [oaids_pkg::VAL_W-1:0] mem_wdata;
    logic [AW-1:0]                      mem_raddr;
    logic signed [oaids_pkg::VAL_W-1:0] mem_rdata;

    // Result handoff between the sequencer and the output register.
    logic            res_valid;
    logic            out_free;
    oaids_pkg::res_t res;

    // Output register: it holds a finished result until the master side takes
    // it, so the sequencer is free to start on the next request meanwhile.
    logic            m_tvalid_reg, m_tvalid_next;
    oaids_pkg::res_t out_reg, out_next;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.rval, out_reg.fpos, out_reg.status};

    oaids_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (req_op),
        .req_val   (req_val),
        .req_pos   (req_pos),
        .res_valid (res_valid),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    oaids_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== verif/tb_ordered_array_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_delete_search_core: self-checking list core bench
// Drives insert, delete, search and read requests into the core and holds a
// model of the list of its own. Each request is predicted when the core
// accepts it, and every result transaction is compared field by field with the
// oldest prediction. Random idle cycles on both channels, a long result
// hold-off and a full drain give back-pressure and pauses at every point of
// the core's work.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete_search_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 4;
    localparam int RESET_TICKS = 9;
    localparam int LIST_DEPTH  = oaids_pkg::DEPTH_DEF;
    // The slowest request walks the whole list; allow some margin on top.
    localparam int DRAIN_TICKS = LIST_DEPTH + 16;
    // Long enough for the core to fill its output register and stall input.
    localparam int HOLD_TICKS  = 400;
    // Cycles without any transaction on either channel before giving up.
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_REQS = 1200;

    localparam logic signed [31:0] V_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] V_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_NEG1 = -32'sd1;

    // One result transaction, split into its fields.
    typedef struct {
        oaids_pkg::status_t status;
        logic [6:0]         fpos;
        logic signed [31:0] rval;
        logic [6:0]         count;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the core. Every input starts at a known
    // value so nothing reaches the core as X.
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] value, [38:32] position, [39] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [1:0] status, [8:2] found_position,
                                  // [40:9] read_value, [47:41] entry_count

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ordered_array_insert_delete_search_core #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Model of the list. It is updated at the moment the core accepts a
    // request, so the stimulus code can always look at the list as the core
    // will see it when the next request arrives.
    // ------------------------------------------------------------------------
    logic signed [31:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;

    list_result_t pending_results [$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int full_rejects   = 0;
    int notfound_count = 0;
    int badpos_count   = 0;
    int op_counts [4]  = '{0, 0, 0, 0};

    // Idle-cycle bookkeeping for both sides.
    int tx_burst_left  = 0;
    int rx_burst_left  = 0;
    int rx_wait        = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int stall_ticks    = 0;

    // Applies one request to the list model and returns the result the core
    // must give for it.
    function automatic list_result_t apply_to_list(oaids_pkg::op_t op,
                                                   logic signed [31:0] val,
                                                   logic [6:0] pos);
        list_result_t r;
        int           p;
        int           i;
        int           hit;
        r   = '{status: oaids_pkg::ST_OK, fpos: '0, rval: '0, count: '0};
        p   = int'(pos);
        hit = -1;
        case (op)
            oaids_pkg::OP_INSERT: begin
                // The position check comes before the capacity check, so an
                // out-of-range insert into a full list reports a bad position.
                if (p < 1 || p > list_len + 1) begin
                    r.status = oaids_pkg::ST_BADPOS;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = oaids_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    list_len++;
                end
            end
            oaids_pkg::OP_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = oaids_pkg::ST_BADPOS;
                end else begin
                    for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            oaids_pkg::OP_SEARCH: begin
                // The lowest matching position wins when values repeat.
                for (i = 0; i < list_len && hit < 0; i++) begin
                    if (list_mem[i] == val) hit = i;
                end
                if (hit < 0) begin
                    r.status = oaids_pkg::ST_NOTFOUND;
                end else begin
                    r.fpos = 7'(hit + 1);
                end
            end
            default: begin
                if (p < 1 || p > list_len) begin
                    r.status = oaids_pkg::ST_BADPOS;
                end else begin
                    r.rval = list_mem[p-1];
                end
            end
        endcase
        r.count = 7'(list_len);
        return r;
    endfunction

    // Idle cycles before the next transaction: mostly a uniform draw, with runs of
    // back-to-back transactions now and then.
    function automatic int next_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(5, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch on result %0d, %s: expected %08h, got %08h",
                     $realtime, results_seen, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side. A request is offered after its idle gap and held until
    // the core takes it. When the gap is zero, s_tvalid simply stays high, so
    // it never gets two assignments in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_request(oaids_pkg::op_t op, logic signed [31:0] val,
                                logic [6:0] pos);
        int gap;
        gap = next_wait(tx_burst_left);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, pos, val};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_to_list(op, val, pos));
        requests_sent++;
        op_counts[int'(op)]++;
    endtask

    // Withdraws the request channel and waits until every result is in. The
    // wait is a do-while loop on the clock, so s_tvalid is never lowered and raised
    // in the same time step.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Outputs are sampled at the rising edge, before the core's
    // own updates take effect. The receiver draws a wait after each result
    // transaction and, on request from a test, holds off for a stretch counted
    // down here from HOLD_TICKS.
    // ------------------------------------------------------------------------
    task automatic compare_result(logic [47:0] beat);
        list_result_t want;
        list_result_t got;
        got.status = oaids_pkg::status_t'(beat[1:0]);
        got.fpos   = beat[8:2];
        got.rval   = beat[40:9];
        got.count  = beat[47:41];
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result without a request", '0, beat[31:0]);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.fpos !== want.fpos)
            report_mismatch("found_position", 32'(want.fpos), 32'(got.fpos));
        if (got.rval !== want.rval)
            report_mismatch("read_value", want.rval, got.rval);
        if (got.count !== want.count)
            report_mismatch("entry_count", 32'(want.count), 32'(got.count));
        case (want.status)
            oaids_pkg::ST_FULL:     full_rejects++;
            oaids_pkg::ST_NOTFOUND: notfound_count++;
            oaids_pkg::ST_BADPOS:   badpos_count++;
            default:                ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) compare_result(m_tdata);
            if (hold_requests != holds_served) begin
                holds_served = holds_served + 1;
                hold_left    = HOLD_TICKS;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                rx_wait = next_wait(rx_burst_left);
                m_tready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= (rx_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run in which neither channel moves until the idle count reaches
    // STALL_LIMIT has hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_ticks <= 0;
            end else begin
                stall_ticks <= stall_ticks + 1;
            end
            if (stall_ticks >= STALL_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("** ordered_array_insert_delete_search_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    // Values lean toward the extremes and a small pool so that repeated
    // values and signed corners turn up often.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0:       return V_MIN;
                1:       return V_MAX;
                2:       return V_NEG1;
                default: return '0;
            endcase
        end
        if (roll <= 3) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Mostly a valid position for the operation; about one in ten is drawn
    // over the whole 7-bit range, which is often out of range.
    function automatic logic [6:0] pick_position(oaids_pkg::op_t op);
        int hi;
        hi = (op == oaids_pkg::OP_INSERT) ? list_len + 1 : list_len;
        if (hi == 0 || $urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, hi));
    endfunction

    // One random request. insert_weight sets the share of inserts in percent
    // and thereby whether the list tends to grow or to shrink.
    task automatic issue_random_request(int insert_weight);
        int                 roll;
        oaids_pkg::op_t     op;
        logic signed [31:0] val;
        logic [6:0]         pos;
        roll = $urandom_range(0, 99);
        if (roll < insert_weight) begin
            op = oaids_pkg::OP_INSERT;
        end else if (roll < 60) begin
            op = oaids_pkg::OP_DELETE;
        end else if (roll < 80) begin
            op = oaids_pkg::OP_SEARCH;
        end else begin
            op = oaids_pkg::OP_READ;
        end
        val = pick_value();
        pos = pick_position(op);
        // Most searches look for a value that is present somewhere.
        if (op == oaids_pkg::OP_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6) begin
            val = list_mem[$urandom_range(0, list_len - 1)];
        end
        send_request(op, val, pos);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    // Corner cases on a fresh list: every operation, bad positions at both
    // ends, signed extremes, repeated values and a search that differs from
    // an entry only in its lowest bit.
    task automatic test_directed_corners();
        send_request(oaids_pkg::OP_SEARCH, V_MAX, 7'd0);       // empty list, no match
        send_request(oaids_pkg::OP_READ, '0, 7'd1);            // nothing to read yet
        send_request(oaids_pkg::OP_DELETE, '0, 7'd1);          // nothing to delete yet
        send_request(oaids_pkg::OP_INSERT, 32'sd5, 7'd0);      // position zero
        send_request(oaids_pkg::OP_INSERT, 32'sd5, 7'd2);      // one past count + 1
        send_request(oaids_pkg::OP_INSERT, 32'sd5, 7'd127);    // all position bits set
        send_request(oaids_pkg::OP_INSERT, V_MIN, 7'd1);
        send_request(oaids_pkg::OP_INSERT, V_MAX, 7'd2);       // append at count + 1
        send_request(oaids_pkg::OP_INSERT, V_NEG1, 7'd1);      // insert at the front
        send_request(oaids_pkg::OP_INSERT, '0, 7'd4);
        send_request(oaids_pkg::OP_INSERT, V_MAX, 7'd2);       // list: -1, MAX, MIN, MAX, 0
        send_request(oaids_pkg::OP_SEARCH, V_MAX, 7'd0);       // lowest of two equal values
        send_request(oaids_pkg::OP_SEARCH, '0, 7'd127);        // match in the last entry
        send_request(oaids_pkg::OP_SEARCH, 32'sd1, 7'd0);
        send_request(oaids_pkg::OP_SEARCH, 32'sh7FFF_FFFE, 7'd0);
        send_request(oaids_pkg::OP_READ, '0, 7'd0);
        send_request(oaids_pkg::OP_READ, '0, 7'd5);            // last entry
        send_request(oaids_pkg::OP_READ, '0, 7'd6);            // one past the end
        send_request(oaids_pkg::OP_READ, '0, 7'd127);
        send_request(oaids_pkg::OP_DELETE, '0, 7'd0);
        send_request(oaids_pkg::OP_DELETE, '0, 7'd6);
        send_request(oaids_pkg::OP_DELETE, '0, 7'd5);          // remove the last entry
        send_request(oaids_pkg::OP_DELETE, '0, 7'd1);          // remove the first entry
        send_request(oaids_pkg::OP_READ, '0, 7'd1);
        send_request(oaids_pkg::OP_SEARCH, V_MIN, 7'd0);
    endtask

    // Fills the list to capacity after a full pause of the request side, then
    // tries inserts at and beyond the limit and touches the top entry.
    task automatic test_fill_to_capacity();
        wait_for_results();
        while (list_len < LIST_DEPTH) begin
            send_request(oaids_pkg::OP_INSERT, pick_value(),
                         7'($urandom_range(1, list_len + 1)));
        end
        send_request(oaids_pkg::OP_INSERT, pick_value(), 7'd1);               // full
        send_request(oaids_pkg::OP_INSERT, pick_value(), 7'(LIST_DEPTH + 1)); // full
        send_request(oaids_pkg::OP_INSERT, pick_value(), 7'(LIST_DEPTH + 2)); // bad position
        send_request(oaids_pkg::OP_READ, $urandom, 7'(LIST_DEPTH));
        send_request(oaids_pkg::OP_READ, $urandom, 7'(LIST_DEPTH + 1));
        send_request(oaids_pkg::OP_SEARCH, list_mem[LIST_DEPTH-1], 7'd0);
        send_request(oaids_pkg::OP_SEARCH, $urandom, 7'd0);
        send_request(oaids_pkg::OP_DELETE, $urandom, 7'd1);                   // longest shift
        send_request(oaids_pkg::OP_INSERT, pick_value(), 7'd1);               // full again
        send_request(oaids_pkg::OP_DELETE, $urandom, 7'(LIST_DEPTH));
        wait_for_results();
    endtask

    // The receiver stops taking results for a long stretch while the sender
    // offers requests back to back; the core must stall its input and lose
    // nothing.
    task automatic test_result_holdoff();
        int n;
        hold_requests <= hold_requests + 1;
        tx_burst_left = 40;
        for (n = 0; n < 30; n++) issue_random_request(35);
        wait_for_results();
    endtask

    // Long random run. The insert share alternates so that the list swings
    // between empty and full several times.
    task automatic test_random_mix();
        int n;
        int weight;
        for (n = 0; n < RANDOM_REQS; n++) begin
            weight = ((n / 150) % 2 == 0) ? 45 : 12;
            issue_random_request(weight);
            if (n % 300 == 299) wait_for_results();
        end
    endtask

    // Empties the list by deletes at random positions, with reads in between,
    // and then searches the empty list and tries a delete on it.
    task automatic test_drain_list();
        while (list_len > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(oaids_pkg::OP_READ, $urandom, 7'($urandom_range(1, list_len)));
            end
            send_request(oaids_pkg::OP_DELETE, $urandom, 7'($urandom_range(1, list_len)));
        end
        send_request(oaids_pkg::OP_SEARCH, '0, 7'd0);
        send_request(oaids_pkg::OP_DELETE, $urandom, 7'd1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_fill_to_capacity();
        test_result_holdoff();
        test_random_mix();
        test_drain_list();

        // Let the last results arrive, then give the core a full walk's worth
        // of cycles to show any stray result transaction.
        wait_for_results();
        repeat (DRAIN_TICKS) @(posedge aclk);

        $display("Checked %0d results for %0d requests: %0d inserts, %0d deletes, ",
                 results_seen, requests_sent, op_counts[int'(oaids_pkg::OP_INSERT)],
                 op_counts[int'(oaids_pkg::OP_DELETE)]);
        $display("%0d searches, %0d reads; %0d full, %0d bad-position, %0d not-found results.",
                 op_counts[int'(oaids_pkg::OP_SEARCH)], op_counts[int'(oaids_pkg::OP_READ)],
                 full_rejects, badpos_count, notfound_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** ordered_array_insert_delete_search_core: PASSED **");
        end else begin
            $display("** ordered_array_insert_delete_search_core: FAILED **");
        end
        $finish;
    end

endmodule
